FILE: rtl/core/guided_chunk_dispenser_top_assert.svh
// Assertion macros shared by the guided chunk dispenser RTL.
`ifndef GUIDED_CHUNK_DISPENSER_TOP_ASSERT_SVH
`define GUIDED_CHUNK_DISPENSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GCDISP_ASSERT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCDISP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gcdisp_pkg.sv
// Package with constants and types of the guided chunk dispenser.
`default_nettype none
package gcdisp_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned OUT_W      = 32;
  localparam int unsigned WORKERS_W  = 7;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned ID_W       = 6;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 72;

  // 2 * workers * (chunk + 1)
  localparam int unsigned THR_W = WORKERS_W + CHUNK_W + 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TOTAL     = 2'd0,
    REG_WORKERS   = 2'd1,
    REG_MIN_CHUNK = 2'd2
  } reg_idx_e;

endpackage
`default_nettype wire

FILE: rtl/core/guided_chunk_dispenser_top.sv
// Guided chunk dispenser: grants loop-iteration chunks to requesting workers.
//
// Usage:
//   Configure total_iterations, worker_count and min_chunk over the cfg write
//   channel (index 0, 1, 2) while no request is in flight. Each beat on the
//   slave stream is one worker request (worker_id in tdata). Each request
//   yields exactly one master beat with the chunk [begin, end), the echoed
//   worker id and, in tuser, a done flag (chunk fields are zero when set).
//   A tail chunk or a done answer passes the calc and final steps before it
//   is registered in the output; a guided chunk also runs a radix-2
//   restoring divide of the remainder by the worker count, one quotient bit
//   per cycle, between those steps. The block takes one request at a time
//   and is ready again in the same cycle that the result becomes valid; the
//   divider loop limits the throughput of guided chunks.
//   Reset clears the cursor to 0 and the registers to total 0, workers 1,
//   chunk 1. A stalled master side holds the result in the output register;
//   the next request may be accepted and computed meanwhile, but it waits
//   in its final step until that result is taken.
`default_nettype none
module guided_chunk_dispenser_top #(
  parameter int unsigned COUNT_WIDTH = gcdisp_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gcdisp_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [gcdisp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [5:0] worker_id, [7:6] zero
  input  wire logic [gcdisp_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [31:0] chunk_begin, [63:32] chunk_end, [69:64] granted_worker, [71:70] zero
  output logic [gcdisp_pkg::M_TDATA_W-1:0]       m_axis_tdata_o,
  // [0] all_done
  output logic                                   m_axis_tuser_o
);

  localparam int unsigned VW    = (COUNT_WIDTH < gcdisp_pkg::OUT_W) ? COUNT_WIDTH
                                                                     : gcdisp_pkg::OUT_W;
  localparam int unsigned CMP_W = (VW > gcdisp_pkg::THR_W) ? VW : gcdisp_pkg::THR_W;
  localparam int unsigned Q_W   = (VW > gcdisp_pkg::CHUNK_W) ? VW : gcdisp_pkg::CHUNK_W;
  localparam int unsigned CNT_W = $clog2(VW + 1);
  localparam int unsigned WC_W  = gcdisp_pkg::WORKERS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [VW-1:0]                   total_q;
  logic [WC_W-1:0]                 workers_q;
  logic [gcdisp_pkg::CHUNK_W-1:0]  chunk_q;
  logic [VW-1:0]                   cursor_q;
  logic [VW-1:0]                   rem_iter_q;   // remainder total - cursor
  logic [gcdisp_pkg::THR_W-1:0]    thr_q;
  logic                            done_q;
  logic                            use_div_q;
  logic [gcdisp_pkg::ID_W-1:0]     id_q;
  logic [VW-1:0]                   dq_q;         // dividend in, quotient out
  logic [WC_W-1:0]                 part_q;       // partial remainder
  logic [CNT_W-1:0]                cnt_q;
  logic                            m_valid_q;
  logic [VW-1:0]                   m_begin_q;
  logic [VW-1:0]                   m_end_q;
  logic [gcdisp_pkg::ID_W-1:0]     m_id_q;
  logic                            m_done_q;

  logic [WC_W-1:0]                 w_eff;
  logic [gcdisp_pkg::CHUNK_W-1:0]  c_eff;
  logic [gcdisp_pkg::THR_W-1:0]    thr_d;
  logic                            s_accept;
  logic                            out_free;
  logic [WC_W:0]                   part_sh;
  logic                            part_ge;
  logic [WC_W-1:0]                 part_d;
  logic [Q_W-1:0]                  q_sel;
  logic                            q_covers;
  logic [VW-1:0]                   end_d;

  assign w_eff = (workers_q == '0) ? WC_W'(1) : workers_q;
  assign c_eff = (chunk_q == '0) ? gcdisp_pkg::CHUNK_W'(1) : chunk_q;
  assign thr_d = (gcdisp_pkg::THR_W'(w_eff) *
                  gcdisp_pkg::THR_W'({1'b0, c_eff} + 17'd1)) << 1;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // One restoring divide step.
  assign part_sh = {part_q, dq_q[VW-1]};
  assign part_ge = (part_sh >= {1'b0, w_eff});
  assign part_d  = part_ge ? WC_W'(part_sh - {1'b0, w_eff}) : WC_W'(part_sh);

  // A guided quotient is at least 2*(chunk+1), so it never needs the chunk floor.
  assign q_sel    = use_div_q ? Q_W'(dq_q) : Q_W'(c_eff);
  assign q_covers = (q_sel >= Q_W'(rem_iter_q));
  assign end_d    = q_covers ? total_q : VW'(cursor_q + q_sel[VW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      workers_q  <= WC_W'(1);
      chunk_q    <= gcdisp_pkg::CHUNK_W'(1);
      cursor_q   <= '0;
      rem_iter_q <= '0;
      thr_q      <= '0;
      done_q     <= 1'b0;
      use_div_q  <= 1'b0;
      id_q       <= '0;
      dq_q       <= '0;
      part_q     <= '0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
      m_begin_q  <= '0;
      m_end_q    <= '0;
      m_id_q     <= '0;
      m_done_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          gcdisp_pkg::REG_TOTAL:     total_q   <= cfg_data_i[VW-1:0];
          gcdisp_pkg::REG_WORKERS:   workers_q <= cfg_data_i[WC_W-1:0];
          gcdisp_pkg::REG_MIN_CHUNK: chunk_q   <= cfg_data_i[gcdisp_pkg::CHUNK_W-1:0];
          default: ;
        endcase
      end

      // Drop the beat once taken; the final step reloads it itself.
      if (m_valid_q && m_axis_tready_i && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            id_q       <= s_axis_tdata_i[gcdisp_pkg::ID_W-1:0];
            done_q     <= (cursor_q >= total_q);
            rem_iter_q <= VW'(total_q - cursor_q);
            thr_q      <= thr_d;
            state_q    <= ST_CALC;
          end
        end
        ST_CALC: begin
          dq_q   <= rem_iter_q;
          part_q <= '0;
          cnt_q  <= '0;
          if (done_q || (CMP_W'(rem_iter_q) < CMP_W'(thr_q))) begin
            use_div_q <= 1'b0;
            state_q   <= ST_FIN;
          end else begin
            use_div_q <= 1'b1;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          dq_q   <= {dq_q[VW-2:0], part_ge};
          part_q <= part_d;
          cnt_q  <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(VW - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hold here until the output register is free.
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_id_q    <= id_q;
            m_done_q  <= done_q;
            if (done_q) begin
              m_begin_q <= '0;
              m_end_q   <= '0;
            end else begin
              m_begin_q <= cursor_q;
              m_end_q   <= end_d;
              cursor_q  <= end_d;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_id_q, gcdisp_pkg::OUT_W'(m_end_q),
                            gcdisp_pkg::OUT_W'(m_begin_q)};
  assign m_axis_tuser_o  = m_done_q;

`include "guided_chunk_dispenser_top_assert.svh"

  `GCDISP_ASSERT(a_grant_nonempty, clk_i, rst_ni,
                 m_valid_q && !m_done_q, m_begin_q < m_end_q,
                 "granted chunk is empty")
  `GCDISP_ASSERT(a_done_zero, clk_i, rst_ni,
                 m_valid_q && m_done_q, (m_begin_q == '0) && (m_end_q == '0),
                 "done beat carries a chunk")
  `GCDISP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
                      s_accept, !s_axis_tready_o,
                      "request taken while busy")
  `GCDISP_ASSERT_NEXT(a_cursor_forward, clk_i, rst_ni,
                      1'b1, cursor_q >= $past(cursor_q),
                      "cursor moved backward")

endmodule
`default_nettype wire
